[sv/rau_pkg.sv]
// Shared constants, operation codes and types of the rational arithmetic unit.
// No dependencies; every other file imports this package.
package rau_pkg;

   // Operand width; the internal widths but the result fields follow from it.
   localparam int OPERAND_WIDTH = 16;
   localparam int MAG_W         = 2*OPERAND_WIDTH + 1;
   localparam int SUM_W         = MAG_W + 1;
   localparam int PROD_W        = 2*OPERAND_WIDTH;
   localparam int CNT_W         = $clog2(MAG_W + 1);
   localparam int MCNT_W        = $clog2(OPERAND_WIDTH + 1);
   localparam int REQ_DATA_W    = ((4*OPERAND_WIDTH + 7) / 8) * 8;

   // Fixed result field widths.
   localparam int NUM_W  = 33;
   localparam int DEN_W  = 31;
   localparam int KIND_W = 2;

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUB = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MUL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DIV = 2'd3;

   // Magnitudes of a fraction.
   typedef struct packed {
      logic [MAG_W-1:0] num;
      logic [MAG_W-1:0] den;
   } rau_frac_type;

endpackage

[sv/rau_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on rau_pkg.
module rau_mul
   import rau_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] mul_a,
   input  logic [OPERAND_WIDTH-1:0] mul_b,
   output logic                     busy,
   output logic [PROD_W-1:0]        prod
);

   logic                     busy_ff, busy_in;
   logic [MCNT_W-1:0]        cnt_ff, cnt_in;
   logic [PROD_W-1:0]        mc_ff, mc_in;
   logic [OPERAND_WIDTH-1:0] mp_ff, mp_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;

   // Add the shifted multiplicand for each set multiplier bit
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      acc_in  = acc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            mc_in   = PROD_W'(mul_a);
            mp_in   = mul_b;
            acc_in  = '0;
         end
      end else begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in  = mc_ff << 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MCNT_W'(OPERAND_WIDTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      acc_ff <= acc_in;
   end

   assign busy = busy_ff;
   assign prod = acc_ff;

endmodule

[sv/rau_reduce.sv]
// Fraction reduction: binary gcd one step per cycle, restoring the common powers of
// two, then two restoring divisions by the gcd, one quotient bit per cycle. Depends on rau_pkg.
module rau_reduce
   import rau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  rau_frac_type mag_in,
   output logic         busy,
   output rau_frac_type quot
);

   localparam logic [1:0] RS_IDLE  = 2'd0;
   localparam logic [1:0] RS_GCD   = 2'd1;
   localparam logic [1:0] RS_SHIFT = 2'd2;
   localparam logic [1:0] RS_DIV   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [MAG_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [CNT_W-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic [MAG_W-1:0] nd_ff, nd_in, dd_ff, dd_in;
   logic [MAG_W:0]   rn_ff, rn_in, rd_ff, rd_in;
   logic [MAG_W-1:0] qn_ff, qn_in, qd_ff, qd_in;
   logic [MAG_W:0]   rn_sh, rd_sh, g_ext;

   // Trial remainders of both divisions
   assign rn_sh = {rn_ff[MAG_W-1:0], nd_ff[MAG_W-1]};
   assign rd_sh = {rd_ff[MAG_W-1:0], dd_ff[MAG_W-1]};
   assign g_ext = {1'b0, y_ff};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      nd_in    = nd_ff;
      dd_in    = dd_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      qn_in    = qn_ff;
      qd_in    = qd_ff;
      unique case (state_ff)
         RS_IDLE: begin
            if (start) begin
               x_in     = mag_in.num;
               y_in     = mag_in.den;
               nd_in    = mag_in.num;
               dd_in    = mag_in.den;
               k_in     = '0;
               state_in = RS_GCD;
            end
         end
         // Binary gcd step; the denominator operand never reaches zero
         RS_GCD: begin
            if (x_ff == '0) begin
               state_in = RS_SHIFT;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         // Restore the common powers of two
         RS_SHIFT: begin
            if (k_ff != '0) begin
               y_in = y_ff << 1;
               k_in = k_ff - 1'b1;
            end else begin
               cnt_in   = '0;
               rn_in    = '0;
               rd_in    = '0;
               state_in = RS_DIV;
            end
         end
         // One quotient bit of each division
         RS_DIV: begin
            if (rn_sh >= g_ext) begin
               rn_in = rn_sh - g_ext;
               qn_in = {qn_ff[MAG_W-2:0], 1'b1};
            end else begin
               rn_in = rn_sh;
               qn_in = {qn_ff[MAG_W-2:0], 1'b0};
            end
            if (rd_sh >= g_ext) begin
               rd_in = rd_sh - g_ext;
               qd_in = {qd_ff[MAG_W-2:0], 1'b1};
            end else begin
               rd_in = rd_sh;
               qd_in = {qd_ff[MAG_W-2:0], 1'b0};
            end
            nd_in  = nd_ff << 1;
            dd_in  = dd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               state_in = RS_IDLE;
            end
         end
         default: state_in = RS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
         k_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
      end
      x_ff  <= x_in;
      y_ff  <= y_in;
      nd_ff <= nd_in;
      dd_ff <= dd_in;
      rn_ff <= rn_in;
      rd_ff <= rd_in;
      qn_ff <= qn_in;
      qd_ff <= qd_in;
   end

   assign busy     = (state_ff != RS_IDLE);
   assign quot.num = qn_ff;
   assign quot.den = qd_ff;

endmodule

[sv/rational_arithmetic_unit.sv]
// Rational arithmetic unit: add, subtract, multiply or divide two fractions
// and return the reduced result. One request at a time; the result passes
// through the bit-serial binary gcd and restoring divide in the reduce units
// (operands, then result) and the shift-and-add multiplies between them.
// Synchronous reset clears the control state only.
// Depends on rau_pkg, rau_reduce and rau_mul.
module rational_arithmetic_unit
   import rau_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // a_num, a_den, b_num, b_den from the lowest bit up
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic [KIND_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // result_num, result_den from the lowest bit up
   output logic [NUM_W+DEN_W-1:0] rsp_tdata,
   // zero_divisor
   output logic                   rsp_tuser
);

   localparam int W = OPERAND_WIDTH;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RED_OP  = 3'd1;
   localparam logic [2:0] ST_MUL     = 3'd2;
   localparam logic [2:0] ST_RED_RES = 3'd3;
   localparam logic [2:0] ST_OUT     = 3'd4;

   function automatic logic [W-1:0] abs_op(input logic [W-1:0] v);
      abs_op = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   logic [2:0]        state_ff, state_in;
   logic [KIND_W-1:0] kind_ff;
   logic              an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic              sa_ff, sb_ff, rn_neg_ff, rd_neg_ff, zdiv_ff;
   logic              rsp_valid_ff;
   logic [NUM_W-1:0]  out_num_ff;
   logic [DEN_W-1:0]  out_den_ff;
   logic              out_zdiv_ff;

   logic [W-1:0]  a_num, a_den, b_num, b_den, ad_v, bd_v;
   logic          accept, op_done, mul_done, res_done, out_load;
   rau_frac_type  op_a, op_b, res_frac, red0_in, quot0, quot1;
   logic          busy0, busy1, mbusy1, mbusy2, mbusy3;
   logic [W-1:0]  ma_n, ma_d, mb_n, mb_d, m1_b, m3_b;
   logic [PROD_W-1:0] p1, p2, p3;
   logic [SUM_W-1:0]  t1, t2, t1m, rn_sum, rn_abs;
   logic          sa, sb, nneg, dzero, out_neg;
   logic [NUM_W-1:0]  q_num;

   // Unpack the request
   assign a_num = req_tdata[W-1:0];
   assign a_den = req_tdata[2*W-1:W];
   assign b_num = req_tdata[3*W-1:2*W];
   assign b_den = req_tdata[4*W-1:3*W];
   assign ad_v  = (a_den == '0) ? W'(1) : a_den;
   assign bd_v  = (b_den == '0) ? W'(1) : b_den;

   assign op_a.num = MAG_W'(abs_op(a_num));
   assign op_a.den = MAG_W'(abs_op(ad_v));
   assign op_b.num = MAG_W'(abs_op(b_num));
   assign op_b.den = MAG_W'(abs_op(bd_v));

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign op_done    = (state_ff == ST_RED_OP) && !busy0 && !busy1;
   assign mul_done   = (state_ff == ST_MUL) && !mbusy1 && !mbusy2 && !mbusy3;
   assign res_done   = (state_ff == ST_RED_RES) && !busy0;
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // Reduced operands
   assign ma_n = W'(quot0.num);
   assign ma_d = W'(quot0.den);
   assign mb_n = W'(quot1.num);
   assign mb_d = W'(quot1.den);
   assign sa   = (an_neg_ff != ad_neg_ff) && (quot0.num != '0);
   assign sb   = (bn_neg_ff != bd_neg_ff) && (quot1.num != '0);
   assign m1_b = (kind_ff == KIND_MUL) ? mb_n : mb_d;
   assign m3_b = (kind_ff == KIND_DIV) ? mb_n : mb_d;

   // Combine the signed cross products
   assign t1  = sa_ff ? (~SUM_W'(p1) + 1'b1) : SUM_W'(p1);
   assign t2  = sb_ff ? (~SUM_W'(p2) + 1'b1) : SUM_W'(p2);
   assign t1m = (sa_ff != sb_ff) ? (~SUM_W'(p1) + 1'b1) : SUM_W'(p1);

   always_comb begin
      unique case (kind_ff)
         KIND_ADD: rn_sum = t1 + t2;
         KIND_SUB: rn_sum = t1 - t2;
         KIND_MUL: rn_sum = t1m;
         KIND_DIV: rn_sum = t1;
         default:  rn_sum = t1;
      endcase
   end

   assign nneg         = rn_sum[SUM_W-1];
   assign rn_abs       = nneg ? (~rn_sum + 1'b1) : rn_sum;
   assign dzero        = (p3 == '0);
   assign res_frac.num = MAG_W'(rn_abs);
   assign res_frac.den = dzero ? MAG_W'(1) : MAG_W'(p3);

   assign red0_in = (state_ff == ST_IDLE) ? op_a : res_frac;

   rau_reduce u_red0 (
      .clock  (clock),
      .reset  (reset),
      .start  (accept || mul_done),
      .mag_in (red0_in),
      .busy   (busy0),
      .quot   (quot0)
   );

   rau_reduce u_red1 (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .mag_in (op_b),
      .busy   (busy1),
      .quot   (quot1)
   );

   rau_mul u_mul1 (
      .clock (clock), .reset (reset), .start (op_done),
      .mul_a (ma_n), .mul_b (m1_b), .busy (mbusy1), .prod (p1)
   );

   rau_mul u_mul2 (
      .clock (clock), .reset (reset), .start (op_done),
      .mul_a (mb_n), .mul_b (ma_d), .busy (mbusy2), .prod (p2)
   );

   rau_mul u_mul3 (
      .clock (clock), .reset (reset), .start (op_done),
      .mul_a (ma_d), .mul_b (m3_b), .busy (mbusy3), .prod (p3)
   );

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept)   state_in = ST_RED_OP;
         ST_RED_OP:  if (op_done)  state_in = ST_MUL;
         ST_MUL:     if (mul_done) state_in = ST_RED_RES;
         ST_RED_RES: if (res_done) state_in = ST_OUT;
         ST_OUT:     if (out_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Final sign
   assign out_neg = (rn_neg_ff != rd_neg_ff) && (quot0.num != '0);
   assign q_num   = NUM_W'(quot0.num);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // Hold request signs and kind
      if (accept) begin
         kind_ff   <= req_tuser;
         an_neg_ff <= a_num[W-1];
         ad_neg_ff <= ad_v[W-1];
         bn_neg_ff <= b_num[W-1];
         bd_neg_ff <= bd_v[W-1];
      end
      if (op_done) begin
         sa_ff <= sa;
         sb_ff <= sb;
      end
      if (mul_done) begin
         rn_neg_ff <= nneg;
         rd_neg_ff <= (kind_ff == KIND_DIV) && sb_ff && !dzero;
         zdiv_ff   <= dzero;
      end
      if (out_load) begin
         out_num_ff  <= out_neg ? (~q_num + 1'b1) : q_num;
         out_den_ff  <= DEN_W'(quot0.den);
         out_zdiv_ff <= zdiv_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_den_ff, out_num_ff};
   assign rsp_tuser  = out_zdiv_ff;

   // Checks
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_den_ff != '0))
      else $error("result denominator is zero");

   a_zdiv_den_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_zdiv_ff) |-> (out_den_ff == DEN_W'(1)))
      else $error("zero divisor result without unit denominator");

   a_start_reduce: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy0 && busy1))
      else $error("operand reduction did not start");

endmodule
